/* hdl/linsch_pkg.sv */
// Shared types, constants and schedule table contents for the LIN schedule sequencer.
// Used by linsch_step and lin_schedule_table_sequencer; depends on nothing.
`timescale 1ns / 1ps

package linsch_pkg;

	localparam int NUM_TABLES = 4;
	localparam int MAX_SLOTS  = 17;

	localparam int TABLE_W = 2;
	localparam int SLOT_W  = 5;
	localparam int SIZE_W  = 6;
	localparam int CODE_W  = 4;
	localparam int TICK_W  = 4;
	localparam int MASK_W  = 4;

	// Input kinds carried on the slave-side tuser
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_CHANGE = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [TICK_W-1:0] ticks;
	} linsch_slot_t;

	typedef struct packed {
		logic [TICK_W-1:0]  tick_count;
		logic [SLOT_W-1:0]  next_slot;
		logic [TABLE_W-1:0] current_table;
		logic [TABLE_W-1:0] pending_table;
		logic               change_pending;
	} linsch_state_t;

	typedef struct packed {
		logic               tx_start;
		logic [CODE_W-1:0]  frame_code;
		logic [TABLE_W-1:0] active_table;
		logic [SLOT_W-1:0]  slot_index;
		logic               table_changed;
		logic               table_end;
	} linsch_result_t;

	// Number of slots in a table, clipped to the slot limit
	function automatic logic [SIZE_W-1:0] table_size(input logic [TABLE_W-1:0] t);
		logic [SIZE_W-1:0] n;
		begin
			case (t)
				2'd0:    n = SIZE_W'(4);
				2'd1:    n = SIZE_W'(8);
				2'd2:    n = SIZE_W'(5);
				default: n = SIZE_W'(17);
			endcase
			if (n > SIZE_W'(MAX_SLOTS))
				n = SIZE_W'(MAX_SLOTS);
			return n;
		end
	endfunction

	// Slot contents of the three basic tables
	function automatic linsch_slot_t slot_ids(input logic [SLOT_W-1:0] s);
		linsch_slot_t r;
		begin
			r.code  = s[CODE_W-1:0];
			r.ticks = TICK_W'(12);
			return r;
		end
	endfunction

	function automatic linsch_slot_t slot_cmds(input logic [SLOT_W-1:0] s);
		linsch_slot_t r;
		begin
			// Alternate a master command with the matching slave response
			r.code  = (s[0] ? CODE_W'(8) : CODE_W'(4)) + CODE_W'(s[2:1]);
			r.ticks = TICK_W'(10);
			return r;
		end
	endfunction

	function automatic linsch_slot_t slot_bcast(input logic [SLOT_W-1:0] s);
		linsch_slot_t r;
		begin
			if (s == '0) begin
				r.code  = CODE_W'(12);
				r.ticks = TICK_W'(10);
			end else begin
				r.code  = CODE_W'(8) + CODE_W'(s - SLOT_W'(1));
				r.ticks = TICK_W'(5);
			end
			return r;
		end
	endfunction

	// Schedule ROM: frame code and slot length for a table and slot
	function automatic linsch_slot_t slot_rom(input logic [TABLE_W-1:0] t,
	                                          input logic [SLOT_W-1:0] s);
		linsch_slot_t r;
		begin
			r = '0;
			case (t)
				2'd0: begin
					if (s < SLOT_W'(4))
						r = slot_ids(s);
				end
				2'd1: begin
					if (s < SLOT_W'(8))
						r = slot_cmds(s);
				end
				2'd2: begin
					if (s < SLOT_W'(5))
						r = slot_bcast(s);
				end
				default: begin
					// Testing table: the three basic tables run back to back
					if (s < SLOT_W'(4))
						r = slot_ids(s);
					else if (s < SLOT_W'(12))
						r = slot_cmds(s - SLOT_W'(4));
					else if (s < SLOT_W'(17))
						r = slot_bcast(s - SLOT_W'(12));
				end
			endcase
			return r;
		end
	endfunction

endpackage

/* hdl/linsch_step.sv */
// Next-state and result logic for one sequencer item.
// Depends on linsch_pkg for the state and result types and the schedule ROM.
`timescale 1ns / 1ps

module linsch_step import linsch_pkg::*; (
	input  logic                cmd,
	input  logic [TABLE_W-1:0]  table_sel,
	input  logic [MASK_W-1:0]   interrupt_mask,
	input  linsch_state_t       state_cur,
	output linsch_state_t       state_nxt,
	output linsch_result_t      result
);

	logic [TABLE_W-1:0] tbl;
	logic [SLOT_W-1:0]  slot_in;
	logic [SIZE_W-1:0]  size;
	logic [SLOT_W-1:0]  slot;
	logic [SIZE_W-1:0]  slot_inc;
	linsch_slot_t       entry;
	logic               apply;

	// Decide whether a pending change may be applied at this boundary
	assign apply = state_cur.change_pending &&
	               (state_cur.next_slot == '0 || interrupt_mask[state_cur.current_table]);
	assign tbl     = apply ? state_cur.pending_table : state_cur.current_table;
	assign slot_in = apply ? '0 : state_cur.next_slot;
	assign size    = table_size(tbl);
	assign slot    = ({1'b0, slot_in} >= size) ? '0 : slot_in;
	assign entry   = slot_rom(tbl, slot);
	assign slot_inc = {1'b0, slot} + SIZE_W'(1);

	always_comb begin
		state_nxt = state_cur;
		result    = '0;
		result.active_table = state_cur.current_table;
		if (cmd == CMD_CHANGE) begin
			// Latch a request only for a different, existing table
			if ({1'b0, table_sel} < (TABLE_W+1)'(NUM_TABLES) &&
			    table_sel != state_cur.current_table) begin
				state_nxt.change_pending = 1'b1;
				state_nxt.pending_table  = table_sel;
			end
		end else if (state_cur.tick_count == '0) begin
			// Start the frame of the current slot and advance
			state_nxt.current_table = tbl;
			if (apply)
				state_nxt.change_pending = 1'b0;
			state_nxt.tick_count = entry.ticks - TICK_W'(1);
			result.tx_start      = 1'b1;
			result.frame_code    = entry.code;
			result.active_table  = tbl;
			result.slot_index    = slot;
			result.table_changed = apply;
			if (slot_inc >= size) begin
				state_nxt.next_slot = '0;
				result.table_end    = 1'b1;
			end else begin
				state_nxt.next_slot = slot_inc[SLOT_W-1:0];
			end
		end else begin
			// Count the slot down
			state_nxt.tick_count = state_cur.tick_count - TICK_W'(1);
		end
	end

endmodule

/* hdl/lin_schedule_table_sequencer.sv */
// LIN master schedule sequencer: four fixed schedule tables stepped by tick items.
// Path: input register, then result register; a held result stalls the input register.
// Throughput: one item per cycle unless the result side stalls; the schedule state is
// updated as each item leaves the input register, so consecutive items need no gap.
// Reset (arst_n low, asynchronous): table 0, slot 0, counter 0, change to table 3
// pending, interrupt_mask = 2, both stages empty. Depends on linsch_pkg, linsch_step.
`timescale 1ns / 1ps

module lin_schedule_table_sequencer import linsch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: interrupt_mask
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// Input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [1:0] table_sel, [7:2] zero
	input  logic        s_axis_tuser,   // [0] cmd
	// Result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [3:0] frame_code, [5:4] active_table,
	                                    // [10:6] slot_index, [11] table_changed,
	                                    // [12] table_end, [15:13] zero
	output logic        m_axis_tuser    // [0] tx_start
);

	logic [MASK_W-1:0]  interrupt_mask_q;
	logic               valid_s1;
	logic               cmd_s1;
	logic [TABLE_W-1:0] table_sel_s1;
	linsch_state_t      state_q;
	linsch_state_t      state_nxt;
	linsch_result_t     result;
	linsch_result_t     result_s2;
	logic               valid_s2;
	logic               advance;

	assign cfg_ready = 1'b1;

	// Hold the mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			interrupt_mask_q <= MASK_W'(2);
		else if (cfg_valid && cfg_ready)
			interrupt_mask_q <= cfg_data;
	end

	// Move the item from the input register to the result register
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1       <= s_axis_tuser;
			table_sel_s1 <= s_axis_tdata[TABLE_W-1:0];
		end
	end

	linsch_step u_step (
		.cmd            (cmd_s1),
		.table_sel      (table_sel_s1),
		.interrupt_mask (interrupt_mask_q),
		.state_cur      (state_q),
		.state_nxt      (state_nxt),
		.result         (result)
	);

	// Schedule state advances once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.tick_count     <= '0;
			state_q.next_slot      <= '0;
			state_q.current_table  <= '0;
			state_q.pending_table  <= TABLE_W'(3);
			state_q.change_pending <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_axis_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = result_s2.tx_start;
	assign m_axis_tdata  = {3'b000, result_s2.table_end, result_s2.table_changed,
	                        result_s2.slot_index, result_s2.active_table,
	                        result_s2.frame_code};

endmodule

/* tb/sv/tb_lin_schedule_table_sequencer.sv */
// Testbench for lin_schedule_table_sequencer: directed and random tick and change streams,
// checked transfer by transfer against a cycle-free model of the schedule tables.
// Depends on linsch_pkg and the lin_schedule_table_sequencer RTL.
`timescale 1ns / 1ps

module tb_lin_schedule_table_sequencer;
	import linsch_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 6;
	localparam int MAX_PRINTS   = 30;

	// Frame codes of the three basic tables, slot 0 in the lowest nibble
	localparam logic [15:0] IDS_CODES   = {4'd3, 4'd2, 4'd1, 4'd0};
	localparam logic [31:0] CMD_CODES   = {4'd11, 4'd7, 4'd10, 4'd6, 4'd9, 4'd5, 4'd8, 4'd4};
	localparam logic [19:0] BCAST_CODES = {4'd11, 4'd10, 4'd9, 4'd8, 4'd12};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;

	// Model of the sequencer state, at reset values
	logic [3:0] m_mask       = 4'd2;
	logic [3:0] m_ticks      = 4'd0;
	logic [4:0] m_slot       = 5'd0;
	logic [1:0] m_table      = 2'd0;
	logic [1:0] m_pend_table = 2'd3;
	logic       m_pending    = 1'b1;

	linsch_result_t pending_results[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  frames_started = 0;
	int  tables_switched = 0;
	int  table_ends = 0;
	bit  calm = 1'b0;
	bit  hold_req = 1'b0;

	lin_schedule_table_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Slot count of a table
	function automatic logic [5:0] slots_in(input logic [1:0] t);
		case (t)
			2'd0:    return 6'd4;
			2'd1:    return 6'd8;
			2'd2:    return 6'd5;
			default: return 6'd17;
		endcase
	endfunction

	// Frame code and length in ticks for one slot; table 3 chains tables 0, 1 and 2
	function automatic linsch_slot_t frame_at(input logic [1:0] t, input logic [4:0] s);
		linsch_slot_t e;
		logic [1:0]   base;
		logic [4:0]   off;
		e = '0;
		base = t;
		off = s;
		if (t == 2'd3) begin
			if (s < 5'd4) begin
				base = 2'd0;
			end else if (s < 5'd12) begin
				base = 2'd1;
				off = s - 5'd4;
			end else begin
				base = 2'd2;
				off = s - 5'd12;
			end
		end
		case (base)
			2'd0: begin
				e.code = IDS_CODES[off[1:0]*4 +: 4];
				e.ticks = 4'd12;
			end
			2'd1: begin
				e.code = CMD_CODES[off[2:0]*4 +: 4];
				e.ticks = 4'd10;
			end
			default: begin
				if (off < 5'd5)
					e.code = BCAST_CODES[off[2:0]*4 +: 4];
				e.ticks = (off == 5'd0) ? 4'd10 : 4'd5;
			end
		endcase
		return e;
	endfunction

	// Advance the model by one item and return the result it causes
	function automatic linsch_result_t schedule_next(input logic cmd, input logic [1:0] sel);
		linsch_result_t r;
		linsch_slot_t   e;
		logic [5:0]     size;
		r = '0;
		if (cmd == CMD_CHANGE) begin
			if (int'(sel) < NUM_TABLES && sel != m_table) begin
				m_pending = 1'b1;
				m_pend_table = sel;
			end
		end else if (m_ticks == 4'd0) begin
			if (m_pending && (m_slot == 5'd0 || m_mask[m_table])) begin
				m_table = m_pend_table;
				m_slot = 5'd0;
				m_pending = 1'b0;
				r.table_changed = 1'b1;
			end
			size = slots_in(m_table);
			if ({1'b0, m_slot} >= size)
				m_slot = 5'd0;
			e = frame_at(m_table, m_slot);
			r.tx_start = 1'b1;
			r.frame_code = e.code;
			r.slot_index = m_slot;
			m_ticks = e.ticks - 4'd1;
			m_slot = m_slot + 5'd1;
			if ({1'b0, m_slot} >= size) begin
				m_slot = 5'd0;
				r.table_end = 1'b1;
			end
		end else begin
			m_ticks = m_ticks - 4'd1;
		end
		r.active_table = m_table;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic compare_result(input linsch_result_t got, input linsch_result_t want);
		if (got.tx_start != want.tx_start)
			report_mismatch("tx_start", int'(got.tx_start), int'(want.tx_start));
		if (got.frame_code != want.frame_code)
			report_mismatch("frame_code", int'(got.frame_code), int'(want.frame_code));
		if (got.active_table != want.active_table)
			report_mismatch("active_table", int'(got.active_table),
			                int'(want.active_table));
		if (got.slot_index != want.slot_index)
			report_mismatch("slot_index", int'(got.slot_index), int'(want.slot_index));
		if (got.table_changed != want.table_changed)
			report_mismatch("table_changed", int'(got.table_changed),
			                int'(want.table_changed));
		if (got.table_end != want.table_end)
			report_mismatch("table_end", int'(got.table_end), int'(want.table_end));
	endtask

	// Track register writes and input transfers, then check each result transfer
	always @(posedge clk) begin : result_check
		linsch_result_t got;
		linsch_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				m_mask = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				items_sent++;
				pending_results.push_back(schedule_next(s_axis_tuser, s_axis_tdata[1:0]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.tx_start = m_axis_tuser;
				got.frame_code = m_axis_tdata[3:0];
				got.active_table = m_axis_tdata[5:4];
				got.slot_index = m_axis_tdata[10:6];
				got.table_changed = m_axis_tdata[11];
				got.table_end = m_axis_tdata[12];
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", results_seen, 0);
				end else begin
					want = pending_results.pop_front();
					compare_result(got, want);
					if (want.tx_start)
						frames_started++;
					if (want.table_changed)
						tables_switched++;
					if (want.table_end)
						table_ends++;
				end
			end
		end
	end

	// Result side: random ready bursts, one long hold on request, steady ready when calm
	initial begin : sink_ctrl
		int run;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				run = $urandom_range(1, 18);
				repeat (run) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				run = calm ? 1 : $urandom_range(1, 24);
				repeat (run) @(posedge clk);
			end
		end
	end

	// Offer one item, with an occasional gap first, and hold it until the transfer
	task automatic send_item(input logic cmd, input logic [1:0] sel);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'd0, sel};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic send_ticks(input int n, input logic [1:0] sel);
		for (int i = 0; i < n; i++)
			send_item(CMD_TICK, sel);
	endtask

	// Stop offering and wait until every outstanding result has been taken
	task automatic wait_drained();
		int waited;
		s_axis_tvalid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Register write; only called with the block idle
	task automatic write_mask(input logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Initial change to table 3, same-table requests, counter countdown
	task automatic test_reset_and_requests();
		send_item(CMD_TICK, 2'd0);
		send_item(CMD_CHANGE, 2'd3);
		send_item(CMD_CHANGE, 2'd0);
		send_item(CMD_CHANGE, 2'd3);
		send_ticks(12, 2'd3);
		wait_drained();
	endtask

	// Pending change taken mid-table once the table is interruptible
	task automatic test_mid_table_switch();
		write_mask(4'hF);
		send_ticks(12, 2'd1);
		wait_drained();
		write_mask(4'h0);
	endtask

	// Mostly tick streams with random change requests under one mask setting
	task automatic test_schedule_phase(input logic [3:0] mask, input int n_items,
	                                   input int change_pct);
		logic [1:0] sel;
		write_mask(mask);
		for (int i = 0; i < n_items; i++) begin
			sel = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 99) < change_pct)
				send_item(CMD_CHANGE, sel);
			else
				send_item(CMD_TICK, sel);
		end
		wait_drained();
	endtask

	// Long hold on the result side while items keep coming, then a full pause
	task automatic test_backpressure();
		logic [1:0] sel;
		logic [3:0] mask;
		mask = 4'($urandom_range(0, 15));
		write_mask(mask);
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++) begin
			sel = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0)
				send_item(CMD_CHANGE, sel);
			else
				send_item(CMD_TICK, sel);
		end
		wait_drained();
	endtask

	// Back-to-back transfers on both sides
	task automatic test_calm_stream();
		logic [3:0] mask;
		mask = 4'($urandom_range(0, 15));
		calm = 1'b1;
		test_schedule_phase(mask, 100, 5);
	endtask

	initial begin : stimulus
		logic [3:0] mask;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= 4'd0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'd0;
		s_axis_tuser <= CMD_TICK;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_requests();
		test_mid_table_switch();
		test_schedule_phase(4'h0, 180, 8);
		test_schedule_phase(4'hF, 150, 4);
		test_schedule_phase(4'h2, 150, 10);
		test_schedule_phase(4'h5, 150, 6);
		test_schedule_phase(4'hA, 150, 6);
		mask = 4'($urandom_range(0, 15));
		test_schedule_phase(mask, 100, 20);
		test_backpressure();
		test_calm_stream();

		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		$display("Covered %0d items and %0d results: %0d frame starts, %0d table switches,",
		         items_sent, results_seen, frames_started, tables_switched);
		$display("%0d table ends, under masks 0, F, 2, 5, A and random ones.", table_ends);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
